@@ src/bise_pkg.sv @@
package bise_pkg;

  localparam int MAX_RANGE = 1024;
  localparam int WORD_BITS = 64;
  localparam int NUM_WORDS = MAX_RANGE / WORD_BITS;
  localparam int ADDR_W    = $clog2(NUM_WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int IDX_W     = $clog2(MAX_RANGE);
  localparam int CNT_W     = IDX_W + 1;
  localparam int OP_W      = 4;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR       = 4'd0,
    OP_FILL        = 4'd1,
    OP_COMPLEMENT  = 4'd2,
    OP_ADD         = 4'd3,
    OP_REMOVE      = 4'd4,
    OP_CONTAINS    = 4'd5,
    OP_FIRST       = 4'd6,
    OP_NEXT        = 4'd7,
    OP_NEXT_SUBSET = 4'd8
  } opcode_e;

  function automatic logic [BIT_W-1:0] find_first(word_t v);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

  function automatic word_t range_mask(logic [ADDR_W-1:0] w, logic [CNT_W-1:0] r);
    logic [CNT_W-BIT_W-1:0] full;
    word_t                  m;
    full = r[CNT_W-1:BIT_W];
    if ({1'b0, w} < full) begin
      m = '1;
    end else if ({1'b0, w} == full) begin
      m = ~({WORD_BITS{1'b1}} << r[BIT_W-1:0]);
    end else begin
      m = '0;
    end
    return m;
  endfunction

endpackage

@@ src/bitmap_index_set_engine.sv @@
// A membership set over indices 0 to range_in_use-1, kept as sixteen 64-bit words in a
// single-port-write memory with a registered read, plus an element count and an iteration
// cursor. Clear, contains, add or remove that leave the set unchanged, errors and unknown
// opcodes give their result without a scan of the words. Add and remove that change the
// set, first and next scan the words from the start point one word per cycle and stop at
// the first member. Fill, complement and next-subset always sweep all sixteen words
// through the memory. One transaction is worked on at a time. The next one is taken in
// the cycle after the result is loaded, even while that result waits at the output. A
// range write empties the set at once through per-word valid flags, with no clearing
// pass.
module bitmap_index_set_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bise_pkg::CNT_W-1:0]          range_in_use_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bise_pkg::OP_W-1:0]           opcode_i,
  input  logic [bise_pkg::IDX_W-1:0]          index_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                hit_o,
  output logic signed [bise_pkg::CNT_W-1:0]   element_o,
  output logic [bise_pkg::CNT_W-1:0]          count_o,
  output logic                                error_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                            state_q, state_d;
  bise_pkg::opcode_e                 op_q, op_d;
  logic [bise_pkg::IDX_W-1:0]        idx_q, idx_d;
  logic                              hit_q, hit_d;
  logic                              err_q, err_d;
  logic [bise_pkg::CNT_W-1:0]        count_q, count_d;
  logic [bise_pkg::IDX_W-1:0]        cur_pos_q, cur_pos_d;
  logic                              cur_vld_q, cur_vld_d;
  logic [bise_pkg::CNT_W-1:0]        range_q, range_d;
  logic [bise_pkg::NUM_WORDS-1:0]    valid_q, valid_d;
  logic [bise_pkg::ADDR_W:0]         ptr_q, ptr_d;
  logic                              dval_q, dval_d;
  logic [bise_pkg::ADDR_W-1:0]       didx_q, didx_d;
  logic [bise_pkg::BIT_W-1:0]        sbit_q, sbit_d;
  logic                              first_q, first_d;
  logic                              found_q, found_d;
  logic [bise_pkg::IDX_W-1:0]        spos_q, spos_d;
  logic                              carry_q, carry_d;
  logic                              out_valid_q, out_valid_d;
  logic                              out_hit_q, out_hit_d;
  logic [bise_pkg::CNT_W-1:0]        out_elem_q, out_elem_d;
  logic [bise_pkg::CNT_W-1:0]        out_count_q, out_count_d;
  logic                              out_err_q, out_err_d;

  bise_pkg::word_t                   mem_q [bise_pkg::NUM_WORDS];
  bise_pkg::word_t                   rd_data_q;
  logic                              rd_ok_q;
  logic                              mem_we;
  logic [bise_pkg::ADDR_W-1:0]       mem_wa;
  logic [bise_pkg::ADDR_W-1:0]       mem_ra;
  bise_pkg::word_t                   mem_wd;

  bise_pkg::word_t                   rd_word;
  bise_pkg::word_t                   mask;
  bise_pkg::word_t                   cand;
  logic                              seek_mode;
  logic                              cur_bit;
  logic [bise_pkg::CNT_W-1:0]        start;
  logic [bise_pkg::CNT_W-1:0]        cfg_range;

  assign rd_word     = rd_data_q & {bise_pkg::WORD_BITS{rd_ok_q}};
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;
  assign element_o   = out_elem_q;
  assign count_o     = out_count_q;
  assign error_o     = out_err_q;

  always_comb begin
    if (range_in_use_i == '0) begin
      cfg_range = bise_pkg::CNT_W'(1);
    end else if (range_in_use_i > bise_pkg::CNT_W'(bise_pkg::MAX_RANGE)) begin
      cfg_range = bise_pkg::CNT_W'(bise_pkg::MAX_RANGE);
    end else begin
      cfg_range = range_in_use_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    hit_d       = hit_q;
    err_d       = err_q;
    count_d     = count_q;
    cur_pos_d   = cur_pos_q;
    cur_vld_d   = cur_vld_q;
    range_d     = range_q;
    valid_d     = valid_q;
    ptr_d       = ptr_q;
    dval_d      = 1'b0;
    didx_d      = didx_q;
    sbit_d      = sbit_q;
    first_d     = first_q;
    found_d     = found_q;
    spos_d      = spos_q;
    carry_d     = carry_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_hit_d   = out_hit_q;
    out_elem_d  = out_elem_q;
    out_count_d = out_count_q;
    out_err_d   = out_err_q;
    mem_we      = 1'b0;
    mem_wa      = didx_q;
    mem_ra      = index_i[bise_pkg::IDX_W-1:bise_pkg::BIT_W];
    mem_wd      = rd_word;
    mask        = bise_pkg::range_mask(didx_q, range_q);
    cand        = '0;
    seek_mode   = !((op_q == bise_pkg::OP_FILL) || (op_q == bise_pkg::OP_COMPLEMENT) ||
                    (op_q == bise_pkg::OP_NEXT_SUBSET));
    cur_bit     = rd_word[idx_q[bise_pkg::BIT_W-1:0]];
    start       = cur_vld_q ? ({1'b0, cur_pos_q} + bise_pkg::CNT_W'(1)) : '0;

    unique case (state_q)
      S_IDLE: begin
        if (cfg_valid_i) begin
          range_d   = cfg_range;
          valid_d   = '0;
          count_d   = '0;
          cur_pos_d = '0;
          cur_vld_d = 1'b0;
        end else if (in_valid_i) begin
          op_d    = bise_pkg::opcode_e'(opcode_i);
          idx_d   = index_i;
          hit_d   = 1'b0;
          err_d   = 1'b0;
          ptr_d   = '0;
          sbit_d  = '0;
          first_d = 1'b1;
          found_d = 1'b0;
          carry_d = 1'b1;
          unique case (opcode_i) inside
            bise_pkg::OP_CLEAR: begin
              valid_d   = '0;
              count_d   = '0;
              cur_pos_d = '0;
              cur_vld_d = 1'b0;
              state_d   = S_DONE;
            end
            bise_pkg::OP_FILL, bise_pkg::OP_COMPLEMENT, bise_pkg::OP_NEXT_SUBSET,
            bise_pkg::OP_FIRST: begin
              state_d = S_SCAN;
            end
            bise_pkg::OP_ADD, bise_pkg::OP_REMOVE, bise_pkg::OP_CONTAINS: begin
              if ({1'b0, index_i} >= range_q) begin
                err_d   = 1'b1;
                state_d = S_DONE;
              end else begin
                state_d = S_RMW;
              end
            end
            bise_pkg::OP_NEXT: begin
              if (count_q == '0) begin
                err_d   = 1'b1;
                state_d = S_DONE;
              end else begin
                ptr_d   = start[bise_pkg::CNT_W-1:bise_pkg::BIT_W];
                sbit_d  = start[bise_pkg::BIT_W-1:0];
                state_d = S_SCAN;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_RMW: begin
        mem_wa = idx_q[bise_pkg::IDX_W-1:bise_pkg::BIT_W];
        mem_wd = rd_word ^ (bise_pkg::word_t'(1) << idx_q[bise_pkg::BIT_W-1:0]);
        if (op_q == bise_pkg::OP_CONTAINS) begin
          hit_d   = cur_bit;
          state_d = S_DONE;
        end else if ((op_q == bise_pkg::OP_ADD) != cur_bit) begin
          mem_we          = 1'b1;
          valid_d[mem_wa] = 1'b1;
          hit_d           = 1'b1;
          count_d         = (op_q == bise_pkg::OP_ADD) ? count_q + bise_pkg::CNT_W'(1)
                                                       : count_q - bise_pkg::CNT_W'(1);
          state_d         = S_SCAN;
        end else begin
          state_d = S_DONE;
        end
      end

      S_SCAN: begin
        if (!ptr_q[bise_pkg::ADDR_W] && !(seek_mode && found_q)) begin
          mem_ra = ptr_q[bise_pkg::ADDR_W-1:0];
          ptr_d  = ptr_q + 1'b1;
          dval_d = 1'b1;
          didx_d = ptr_q[bise_pkg::ADDR_W-1:0];
        end
        if (dval_q) begin
          first_d = 1'b0;
          case (op_q)
            bise_pkg::OP_FILL: begin
              mem_we = 1'b1;
              mem_wd = mask;
            end
            bise_pkg::OP_COMPLEMENT: begin
              mem_we = 1'b1;
              mem_wd = rd_word ^ mask;
              cand   = rd_word ^ mask;
            end
            bise_pkg::OP_NEXT_SUBSET: begin
              mem_we  = 1'b1;
              mem_wd  = (rd_word + bise_pkg::word_t'(carry_q)) & mask;
              carry_d = carry_q && (rd_word == mask);
              cand    = carry_q ? (~rd_word & mask) : '0;
            end
            default: begin
              cand = first_q ? (rd_word & ({bise_pkg::WORD_BITS{1'b1}} << sbit_q)) : rd_word;
            end
          endcase
          if (mem_we) begin
            valid_d[didx_q] = 1'b1;
          end
          if (!found_q && (cand != '0)) begin
            found_d = 1'b1;
            spos_d  = {didx_q, bise_pkg::find_first(cand)};
          end
        end
        if ((seek_mode && found_q) || (!dval_q && ptr_q[bise_pkg::ADDR_W])) begin
          cur_pos_d = found_q ? spos_q : '0;
          cur_vld_d = found_q;
          case (op_q)
            bise_pkg::OP_FILL: begin
              count_d   = range_q;
              cur_pos_d = '0;
              cur_vld_d = 1'b1;
            end
            bise_pkg::OP_COMPLEMENT: begin
              count_d = range_q - count_q;
            end
            bise_pkg::OP_NEXT_SUBSET: begin
              hit_d   = found_q;
              count_d = found_q ? count_q - {1'b0, spos_q} + bise_pkg::CNT_W'(1) : '0;
            end
            default: begin
            end
          endcase
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_hit_d   = hit_q;
          out_elem_d  = cur_vld_q ? {1'b0, cur_pos_q} : '1;
          out_count_d = count_q;
          out_err_d   = err_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem_q[mem_ra];
    rd_ok_q   <= valid_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= bise_pkg::OP_CLEAR;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      err_q       <= 1'b0;
      count_q     <= '0;
      cur_pos_q   <= '0;
      cur_vld_q   <= 1'b0;
      range_q     <= bise_pkg::CNT_W'(bise_pkg::MAX_RANGE);
      valid_q     <= '0;
      ptr_q       <= '0;
      dval_q      <= 1'b0;
      didx_q      <= '0;
      sbit_q      <= '0;
      first_q     <= 1'b0;
      found_q     <= 1'b0;
      spos_q      <= '0;
      carry_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
      out_elem_q  <= '0;
      out_count_q <= '0;
      out_err_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      idx_q       <= idx_d;
      hit_q       <= hit_d;
      err_q       <= err_d;
      count_q     <= count_d;
      cur_pos_q   <= cur_pos_d;
      cur_vld_q   <= cur_vld_d;
      range_q     <= range_d;
      valid_q     <= valid_d;
      ptr_q       <= ptr_d;
      dval_q      <= dval_d;
      didx_q      <= didx_d;
      sbit_q      <= sbit_d;
      first_q     <= first_d;
      found_q     <= found_d;
      spos_q      <= spos_d;
      carry_q     <= carry_d;
      out_valid_q <= out_valid_d;
      out_hit_q   <= out_hit_d;
      out_elem_q  <= out_elem_d;
      out_count_q <= out_count_d;
      out_err_q   <= out_err_d;
    end
  end

endmodule

@@ src/bise_checker.sv @@
module bise_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic                               hit_o,
  input logic signed [bise_pkg::CNT_W-1:0]  element_o,
  input logic [bise_pkg::CNT_W-1:0]         count_o,
  input logic                               error_o
);

  // A stalled result transaction stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(element_o) && $stable(count_o) &&
    $stable(hit_o) && $stable(error_o))
    else $error("stalled result changed");

  a_err_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> !hit_o)
    else $error("error reported together with hit");

  a_empty_no_elem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (count_o == '0) |-> (element_o == {bise_pkg::CNT_W{1'b1}}))
    else $error("cursor element reported on an empty set");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_o <= bise_pkg::CNT_W'(bise_pkg::MAX_RANGE)))
    else $error("count above range limit");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction taken while one is in progress");

endmodule

bind bitmap_index_set_engine bise_checker u_bise_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .hit_o       (hit_o),
  .element_o   (element_o),
  .count_o     (count_o),
  .error_o     (error_o)
);
